// ----- sv/histogram_valley_threshold_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the histogram valley threshold block
// Immediate-implication and next-cycle-implication checks, reset aware.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_VALLEY_THRESHOLD_TOP_MACROS_SVH
`define HISTOGRAM_VALLEY_THRESHOLD_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define HVT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define HVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/hvt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared widths, types and helper functions of the histogram valley block.
// ----------------------------------------------------------------------------
package hvt_pkg;

  localparam int BINS         = 256;
  localparam int LVL_W        = 8;
  localparam int COUNT_W      = 21;
  localparam int MAX_THR      = 64;
  localparam int LIST_AW      = 6;
  localparam int TOTAL_W      = 7;
  localparam int WIN_W        = 4;
  localparam int WIN_MAX      = 8;
  localparam int WIN_MIN      = 1;
  localparam int WIN_RESET    = 4;
  localparam int SHIFT_LEN    = 2 * WIN_MAX + 1;
  localparam int TREE_N       = 2 * WIN_MAX;
  localparam int FLUSH_W      = 2;
  localparam int DIV3_MUL     = 683;
  localparam int DIV3_SHIFT   = 11;
  localparam int SUM_W        = 10;
  localparam int PROD_W       = 20;
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 3;

  // Register index, taken from the word address bit of paddr
  localparam logic REG_WINDOW = 1'b0;

  typedef logic [COUNT_W-1:0] count_t;
  typedef count_t [TREE_N-1:0] count_vec_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_ACCUM,
    ST_DRAIN,
    ST_SCAN,
    ST_FLUSH,
    ST_MED_RD,
    ST_MED_LD,
    ST_ITEM_RD,
    ST_ITEM_LD,
    ST_NONE
  } hvt_state_t;

  // One bin read out of the histogram during the scan
  typedef struct packed {
    logic             valid;
    logic [LVL_W-1:0] idx;
    count_t           count;
  } bin_beat_t;

  // Valley decision for one level
  typedef struct packed {
    logic             hit;
    logic [LVL_W-1:0] level;
  } hit_t;

  // floor(sum / 3) for sums below 768, by reciprocal multiply
  function automatic logic [LVL_W-1:0] div3(input logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);
    return prod[DIV3_SHIFT +: LVL_W];
  endfunction

  // Minimum of TREE_N counts as a balanced four-level tree
  function automatic count_t min_tree(input count_vec_t v);
    count_t l1 [8];
    count_t l2 [4];
    count_t l3 [2];
    for (int i = 0; i < 8; i++) begin
      l1[i] = (v[2*i] < v[2*i+1]) ? v[2*i] : v[2*i+1];
    end
    for (int i = 0; i < 4; i++) begin
      l2[i] = (l1[2*i] < l1[2*i+1]) ? l1[2*i] : l1[2*i+1];
    end
    for (int i = 0; i < 2; i++) begin
      l3[i] = (l2[2*i] < l2[2*i+1]) ? l2[2*i] : l2[2*i+1];
    end
    return (l3[0] < l3[1]) ? l3[0] : l3[1];
  endfunction

endpackage
`default_nettype wire

// ----- sv/histogram_valley_threshold_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_valley_threshold_top
// Pixels go in one per beat; each is reduced to brightness (r+g+b)/3 and
// counted in a 256 x 21-bit histogram memory by read-modify-write, with the
// previous write forwarded so one pixel is taken every cycle while the
// block accumulates. After reset a clearing pass zeroes all 256 bins before
// the first pixel is taken. On the pixel marked tlast the input is held off:
// the drain state finishes the last update, then the histogram is read out
// one bin per cycle (clearing each bin behind the read) through a window
// detector, and the flush state drains the pipeline. Thresholds are written
// to a 64-entry list memory; each result then costs a list read (ITEM_RD,
// ITEM_LD) plus any output stall, the median is fetched first (MED_RD,
// MED_LD), and an image with no threshold yields a single result with tuser
// low. The input reopens once the last result sits in the output register.
// ----------------------------------------------------------------------------
module histogram_valley_threshold_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Pixel stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  wire logic        in_tlast,   // last_pixel
  // Threshold stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // threshold_level[7:0], threshold_index[13:8],
                                       // threshold_count[20:14], median_level[28:21]
  output logic             out_tuser,  // found
  output logic             out_tlast,  // last_result
  // Configuration
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [hvt_pkg::APB_AW-1:0]   cfg_paddr,
  input  wire logic [hvt_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [hvt_pkg::APB_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);
  import hvt_pkg::*;

  `include "histogram_valley_threshold_top_macros.svh"

  hvt_state_t         state_r;
  hvt_state_t         state_nxt;
  logic [LVL_W-1:0]   addr_cnt_r;
  logic [FLUSH_W-1:0] flush_cnt_r;

  logic [WIN_W-1:0]   window_r;
  logic [WIN_W-1:0]   win_eff;
  logic               cfg_wr;

  // Control decoded from the state
  logic               in_ready_c;
  logic               clear_c;
  logic               scan_c;
  logic               flush_c;
  logic               list_rd_en;
  logic [LIST_AW-1:0] list_rd_addr;
  logic               med_ld_c;
  logic               load_item;
  logic               load_none;
  logic               out_free;

  // Histogram memory
  count_t             bin_mem [BINS];
  count_t             rd_data_r;
  logic               rd_en;
  logic [LVL_W-1:0]   rd_addr;
  logic               wr_en;
  logic [LVL_W-1:0]   wr_addr;
  count_t             wr_data;

  // Accumulate path
  logic               in_accept;
  logic [LVL_W-1:0]   pix_lvl;
  logic               s1_v_r;
  logic [LVL_W-1:0]   s1_lvl_r;
  logic               fwd_v_r;
  logic [LVL_W-1:0]   fwd_addr_r;
  count_t             fwd_data_r;
  count_t             cur_count;
  count_t             inc_count;

  // Scan path
  logic               scan_v_r;
  logic [LVL_W-1:0]   scan_idx_r;
  bin_beat_t          det_beat;
  hit_t               det_hit;

  // Threshold list
  logic [LVL_W-1:0]   list_mem [MAX_THR];
  logic [LVL_W-1:0]   list_rd_data_r;
  logic               list_wr_en;
  logic [TOTAL_W-1:0] total_r;
  logic [LIST_AW-1:0] k_r;
  logic [LVL_W-1:0]   med_r;
  logic               last_item;

  // Output register
  logic               out_valid_r;
  logic [LVL_W-1:0]   out_level_r;
  logic [LIST_AW-1:0] out_index_r;
  logic [TOTAL_W-1:0] out_count_r;
  logic [LVL_W-1:0]   out_median_r;
  logic               out_found_r;
  logic               out_last_r;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WIN_W'(WIN_RESET);
    end else if (cfg_wr && (cfg_paddr[2] == REG_WINDOW)) begin
      window_r <= cfg_pwdata[WIN_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_WINDOW) ? APB_DW'(window_r) : '0;

  // Clamp the window to 1..8
  always_comb begin
    if (window_r < WIN_W'(WIN_MIN)) begin
      win_eff = WIN_W'(WIN_MIN);
    end else if (window_r > WIN_W'(WIN_MAX)) begin
      win_eff = WIN_W'(WIN_MAX);
    end else begin
      win_eff = window_r;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign last_item = (TOTAL_W'(k_r) + TOTAL_W'(1)) == total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (addr_cnt_r == '1) state_nxt = ST_ACCUM;
      end
      ST_ACCUM: begin
        if (in_accept && in_tlast) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (addr_cnt_r == '1) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (flush_cnt_r == '1) begin
          state_nxt = (total_r == '0) ? ST_NONE : ST_MED_RD;
        end
      end
      ST_MED_RD: begin
        state_nxt = ST_MED_LD;
      end
      ST_MED_LD: begin
        state_nxt = ST_ITEM_RD;
      end
      ST_ITEM_RD: begin
        state_nxt = ST_ITEM_LD;
      end
      ST_ITEM_LD: begin
        if (out_free) state_nxt = last_item ? ST_ACCUM : ST_ITEM_RD;
      end
      ST_NONE: begin
        if (out_free) state_nxt = ST_ACCUM;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_c   = 1'b0;
    clear_c      = 1'b0;
    scan_c       = 1'b0;
    flush_c      = 1'b0;
    list_rd_en   = 1'b0;
    list_rd_addr = k_r;
    med_ld_c     = 1'b0;
    load_item    = 1'b0;
    load_none    = 1'b0;
    unique case (state_r)
      ST_CLEAR:   clear_c = 1'b1;
      ST_ACCUM:   in_ready_c = 1'b1;
      ST_DRAIN:   ;
      ST_SCAN:    scan_c = 1'b1;
      ST_FLUSH:   flush_c = 1'b1;
      ST_MED_RD: begin
        list_rd_en   = 1'b1;
        list_rd_addr = total_r[TOTAL_W-1:1];
      end
      ST_MED_LD:  med_ld_c = 1'b1;
      ST_ITEM_RD: list_rd_en = 1'b1;
      ST_ITEM_LD: load_item = out_free;
      ST_NONE:    load_none = out_free;
      default:    ;
    endcase
  end

  assign in_tready = in_ready_c;

  // Sweep counter for the clearing pass and the scan; wraps back to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_cnt_r  <= '0;
      flush_cnt_r <= '0;
    end else begin
      if (clear_c || scan_c) addr_cnt_r <= addr_cnt_r + LVL_W'(1);
      flush_cnt_r <= flush_c ? flush_cnt_r + FLUSH_W'(1) : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Histogram memory: one read port, one write port, registered read
  // --------------------------------------------------------------------------
  assign pix_lvl = div3(SUM_W'(in_tdata[7:0]) + SUM_W'(in_tdata[15:8])
                        + SUM_W'(in_tdata[23:16]));

  assign rd_en   = in_accept || scan_c;
  assign rd_addr = scan_c ? addr_cnt_r : pix_lvl;

  // Zero bins behind the scan read and during the clearing pass
  assign wr_en   = s1_v_r || clear_c || scan_c;
  assign wr_addr = s1_v_r ? s1_lvl_r : addr_cnt_r;
  assign wr_data = s1_v_r ? inc_count : '0;

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= bin_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) bin_mem[wr_addr] <= wr_data;
  end

  // Forward the update written at the same edge as our read
  assign cur_count = (fwd_v_r && (fwd_addr_r == s1_lvl_r)) ? fwd_data_r : rd_data_r;
  assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      s1_v_r  <= in_accept;
      fwd_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_lvl_r <= pix_lvl;
    fwd_addr_r <= s1_lvl_r;
    fwd_data_r <= inc_count;
  end

  // --------------------------------------------------------------------------
  // Scan: feed bins to the window detector
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_v_r <= 1'b0;
    end else begin
      scan_v_r <= scan_c;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_c) scan_idx_r <= addr_cnt_r;
  end

  assign det_beat = '{valid: scan_v_r, idx: scan_idx_r, count: rd_data_r};

  hvt_valley_det u_det (
    .clk   (clk),
    .rst_n (rst_n),
    .win   (win_eff),
    .beat  (det_beat),
    .hit   (det_hit)
  );

  // --------------------------------------------------------------------------
  // Threshold list: keep the first MAX_THR hits
  // --------------------------------------------------------------------------
  assign list_wr_en = det_hit.hit && (total_r < TOTAL_W'(MAX_THR));

  always_ff @(posedge clk) begin
    if (list_wr_en) list_mem[total_r[LIST_AW-1:0]] <= det_hit.level;
  end

  always_ff @(posedge clk) begin
    if (list_rd_en) list_rd_data_r <= list_mem[list_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      k_r     <= '0;
    end else begin
      if (state_r == ST_DRAIN) begin
        total_r <= '0;
      end else if (list_wr_en) begin
        total_r <= total_r + TOTAL_W'(1);
      end
      if (med_ld_c) begin
        k_r <= '0;
      end else if (load_item) begin
        k_r <= k_r + LIST_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (med_ld_c) med_r <= list_rd_data_r;
  end

  // --------------------------------------------------------------------------
  // Output register: hold a beat until taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_item || load_none) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_item) begin
      out_level_r  <= list_rd_data_r;
      out_index_r  <= k_r;
      out_count_r  <= total_r;
      out_median_r <= med_r;
      out_found_r  <= 1'b1;
      out_last_r   <= last_item;
    end else if (load_none) begin
      out_level_r  <= '0;
      out_index_r  <= '0;
      out_count_r  <= '0;
      out_median_r <= '0;
      out_found_r  <= 1'b0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_median_r, out_count_r, out_index_r, out_level_r};
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `HVT_ASSERT_SAME(a_total_cap, clk, rst_n, 1'b1, total_r <= TOTAL_W'(MAX_THR), "valley total over list depth")
  `HVT_ASSERT_SAME(a_empty_beat, clk, rst_n, out_valid_r && !out_found_r, (out_count_r == '0) && out_last_r, "empty result not single")
  `HVT_ASSERT_SAME(a_last_index, clk, rst_n, out_valid_r && out_found_r && out_last_r, (TOTAL_W'(out_index_r) + TOTAL_W'(1)) == out_count_r, "last result index mismatch")
  `HVT_ASSERT_NEXT(a_drain_update, clk, rst_n, in_accept && in_tlast, (state_r == ST_DRAIN) && s1_v_r, "last pixel update not pending")

endmodule
`default_nettype wire

// ----- sv/hvt_valley_det.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvt_valley_det
// Sliding window over the scanned bins; flags a level whose count lies
// strictly below the minimum of the window bins on both sides.
// ----------------------------------------------------------------------------
module hvt_valley_det (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [hvt_pkg::WIN_W-1:0] win,
  input  wire hvt_pkg::bin_beat_t        beat,
  output hvt_pkg::hit_t                  hit
);
  import hvt_pkg::*;

  count_t           sh_r [SHIFT_LEN];
  logic             sh_v_r;
  logic [LVL_W-1:0] sh_idx_r;

  count_vec_t       up_v;
  count_vec_t       dn_v;
  count_t           up_min;
  count_t           dn_min;
  count_t           center;
  logic             testable;

  logic             hit_v_r;
  logic [LVL_W-1:0] hit_lvl_r;

  // Shift the newest bin in; sh_r[0] holds bin sh_idx_r
  always_ff @(posedge clk) begin
    if (beat.valid) begin
      sh_r[0]  <= beat.count;
      sh_idx_r <= beat.idx;
      for (int i = 1; i < SHIFT_LEN; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_v_r <= 1'b0;
    end else begin
      sh_v_r <= beat.valid;
    end
  end

  // Mask the bins above (taps below win) and below (taps win+1..2*win)
  always_comb begin
    for (int i = 0; i < TREE_N; i++) begin
      up_v[i] = (5'(i) < {1'b0, win}) ? sh_r[i] : COUNT_MAX;
      dn_v[i] = ((5'(i + 1) > {1'b0, win}) && (5'(i + 1) <= {win, 1'b0}))
                ? sh_r[i+1] : COUNT_MAX;
    end
  end

  assign up_min = min_tree(up_v);
  assign dn_min = min_tree(dn_v);

  // Pick the candidate level's own count
  always_comb begin
    center = sh_r[WIN_MIN];
    for (int i = WIN_MIN; i <= WIN_MAX; i++) begin
      if (win == WIN_W'(i)) begin
        center = sh_r[i];
      end
    end
  end

  // Level sh_idx_r - win is in range once 2*win bins have gone by
  assign testable = sh_v_r && (sh_idx_r >= LVL_W'({win, 1'b0}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_v_r <= 1'b0;
    end else begin
      hit_v_r <= testable && (up_min > center) && (dn_min > center);
    end
  end

  always_ff @(posedge clk) begin
    hit_lvl_r <= sh_idx_r - LVL_W'(win);
  end

  assign hit = '{hit: hit_v_r, level: hit_lvl_r};

endmodule
`default_nettype wire
